// File: hdl/efws_pkg.sv
// Shared types and constants for the earliest-free worker scheduler.
package efws_pkg;

  // Configuration register file
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WORKER_COUNT = 2'd0;
  localparam int CFG_DATA_BITS = 32;

  // Worker count register
  localparam int WORKER_COUNT_BITS = 5;
  localparam logic [WORKER_COUNT_BITS-1:0] WORKER_COUNT_RESET = 5'd16;

  // Result field widths
  localparam int ID_FIELD_BITS = 4;
  localparam int START_BITS    = 48;

  // Input field width
  localparam int DURATION_BITS = 32;

  // Control broadcast from the top level to every queue cell
  typedef struct packed {
    logic                         init;        // reload ids, zero free times
    logic [WORKER_COUNT_BITS-1:0] init_count;  // raw worker count for the reload
    logic                         insert;      // pop head and insert pending entry
  } cell_ctrl_t;

endpackage

// File: hdl/efws_cell.sv
// One cell of the sorted worker queue: holds one (free time, id) entry.
module efws_cell #(
  parameter int INDEX     = 0,
  parameter int TIME_BITS = 48,
  parameter int ID_BITS   = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  efws_pkg::cell_ctrl_t  ctrl,
  input  logic [TIME_BITS-1:0]  ins_time,
  input  logic [ID_BITS-1:0]    ins_id,
  input  logic                  right_valid,
  input  logic                  right_lt,
  input  logic [TIME_BITS-1:0]  right_time,
  input  logic [ID_BITS-1:0]    right_id,
  output logic                  valid,
  output logic                  lt,
  output logic [TIME_BITS-1:0]  ent_time,
  output logic [ID_BITS-1:0]    wid
);

  logic                 left_lt;
  logic                 valid_next;
  logic [TIME_BITS-1:0] ent_time_next;
  logic [ID_BITS-1:0]   wid_next;

  // This entry sorts ahead of the entry being inserted
  assign lt = valid && ((ent_time < ins_time) ||
                        ((ent_time == ins_time) && (wid < ins_id)));

  // The head leaves on insert, so the first cell always sees its left slot as ahead
  assign left_lt = (INDEX == 0) ? 1'b1 : lt;

  // Shift toward the head and drop the new entry into its sorted slot
  always_comb begin
    priority if (right_lt) begin
      valid_next    = right_valid;
      ent_time_next = right_time;
      wid_next      = right_id;
    end else if (left_lt) begin
      valid_next    = 1'b1;
      ent_time_next = ins_time;
      wid_next      = ins_id;
    end else begin
      valid_next    = valid;
      ent_time_next = ent_time;
      wid_next      = wid;
    end
  end

  // Entry storage; reset and count writes reload id INDEX at time zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= (INDEX == 0) || (INDEX < int'(efws_pkg::WORKER_COUNT_RESET));
      ent_time <= '0;
      wid      <= ID_BITS'(INDEX);
    end else if (ctrl.init) begin
      valid    <= (INDEX == 0) || (INDEX < int'(ctrl.init_count));
      ent_time <= '0;
      wid      <= ID_BITS'(INDEX);
    end else if (ctrl.insert) begin
      valid    <= valid_next;
      ent_time <= ent_time_next;
      wid      <= wid_next;
    end
  end

endmodule

// File: hdl/efws_out_queue.sv
// Two-entry result buffer between the scheduler and the grant channel.
module efws_out_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [efws_pkg::ID_FIELD_BITS-1:0]  push_id,
  input  logic [efws_pkg::START_BITS-1:0]     push_start,
  output logic                                full,
  output logic                                grant_valid,
  input  logic                                grant_stall,
  output logic [efws_pkg::ID_FIELD_BITS-1:0]  worker_id,
  output logic [efws_pkg::START_BITS-1:0]     start_time
);

  logic [efws_pkg::ID_FIELD_BITS-1:0] q_id    [2];
  logic [efws_pkg::START_BITS-1:0]    q_start [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop         = grant_valid && !grant_stall;
  assign full        = (count == 2'd2);
  assign grant_valid = (count != 2'd0);
  assign worker_id   = q_id[rd_ptr];
  assign start_time  = q_start[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_id[wr_ptr]    <= push_id;
      q_start[wr_ptr] <= push_start;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/earliest_free_worker_scheduler_core.sv
// Top level of the earliest-free worker scheduler: sorted cell chain, control and APB port.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------
//   job      | job_valid / job_stall | job_duration
//   grant    | grant_valid / grant_stall | worker_id, start_time
//   config   | APB psel/penable/pready | paddr, pwdata, prdata
//
// For each job, the transfer cycle reads the head cell and adds the duration,
// and the next cycle pops the head and inserts the updated entry into the
// cell chain in one systolic step. job_stall is high during that insert cycle.
// Up to two results are buffered; job_stall also rises while both are waiting.
// Synchronous reset loads ids 0..15 at free time zero; a worker_count write
// reloads the chain the same way.
module earliest_free_worker_scheduler_core #(
  parameter int MAX_WORKERS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // job channel
  input  logic                                 job_valid,
  output logic                                 job_stall,
  input  logic [efws_pkg::DURATION_BITS-1:0]   job_duration,
  // grant channel
  output logic                                 grant_valid,
  input  logic                                 grant_stall,
  output logic [efws_pkg::ID_FIELD_BITS-1:0]   worker_id,
  output logic [efws_pkg::START_BITS-1:0]      start_time,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [efws_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [efws_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [efws_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  localparam int IdBits      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int IdFieldBits = efws_pkg::ID_FIELD_BITS;
  localparam int StartBits   = efws_pkg::START_BITS;
  localparam int CountBits   = efws_pkg::WORKER_COUNT_BITS;
  localparam int DataBits    = efws_pkg::CFG_DATA_BITS;

  // Configuration register
  logic [CountBits-1:0] worker_count;
  logic                 cfg_write;

  // Insert pipeline
  logic                 busy;
  logic [TIME_BITS-1:0] ins_time;
  logic [IdBits-1:0]    ins_id;
  logic                 accept;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] sum_sat;
  logic                 out_full;
  efws_pkg::cell_ctrl_t ctrl;

  // Cell chain
  logic                 cell_valid [MAX_WORKERS+1];
  logic                 cell_lt    [MAX_WORKERS+1];
  logic [TIME_BITS-1:0] cell_time  [MAX_WORKERS+1];
  logic [IdBits-1:0]    cell_id    [MAX_WORKERS+1];
  logic [MAX_WORKERS-1:0] valid_vec;

  // APB access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr == efws_pkg::REG_WORKER_COUNT);

  always_comb begin
    if (paddr == efws_pkg::REG_WORKER_COUNT) prdata = DataBits'(worker_count);
    else                                     prdata = '0;
  end

  always_ff @(posedge clk) begin
    if (rst)            worker_count <= efws_pkg::WORKER_COUNT_RESET;
    else if (cfg_write) worker_count <= pwdata[CountBits-1:0];
  end

  // Job transfer: head is the earliest free worker
  assign job_stall = busy || out_full;
  assign accept    = job_valid && !job_stall;

  // Saturating free-time update
  assign sum     = {1'b0, cell_time[0]} + (TIME_BITS+1)'(job_duration);
  assign sum_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      ins_time <= sum_sat;
      ins_id   <= cell_id[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else     busy <= accept;
  end

  // Broadcast control to the chain
  always_comb begin
    ctrl.init       = cfg_write;
    ctrl.init_count = pwdata[CountBits-1:0];
    ctrl.insert     = busy;
  end

  // Sorted chain, head at index 0; the slot past the tail is always empty
  assign cell_valid[MAX_WORKERS] = 1'b0;
  assign cell_lt[MAX_WORKERS]    = 1'b0;
  assign cell_time[MAX_WORKERS]  = '0;
  assign cell_id[MAX_WORKERS]    = '0;

  for (genvar g = 0; g < MAX_WORKERS; g++) begin : g_cell
    efws_cell #(
      .INDEX     (g),
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (IdBits)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .ins_time    (ins_time),
      .ins_id      (ins_id),
      .right_valid (cell_valid[g+1]),
      .right_lt    (cell_lt[g+1]),
      .right_time  (cell_time[g+1]),
      .right_id    (cell_id[g+1]),
      .valid       (cell_valid[g]),
      .lt          (cell_lt[g]),
      .ent_time    (cell_time[g]),
      .wid         (cell_id[g])
    );
    assign valid_vec[g] = cell_valid[g];
  end

  // Result buffer
  efws_out_queue u_out_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_id     (IdFieldBits'(cell_id[0])),
    .push_start  (StartBits'(cell_time[0])),
    .full        (out_full),
    .grant_valid (grant_valid),
    .grant_stall (grant_stall),
    .worker_id   (worker_id),
    .start_time  (start_time)
  );

  // An accepted job is inserted in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted job not followed by insert cycle");

  // Insert cycles are never back to back
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("insert cycle lasted more than one cycle");

  // The head cell always holds a worker
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0])
    else $error("head cell empty");

  // Pop-and-insert keeps the number of workers in the chain
  a_count_kept: assert property (@(posedge clk) disable iff (rst)
    busy && !cfg_write |=> $countones(valid_vec) == $past($countones(valid_vec)))
    else $error("insert changed the number of queued workers");

  // A count write restarts with worker 0 free at time zero
  a_cfg_head: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (cell_time[0] == '0) && (cell_id[0] == '0))
    else $error("count write did not reload the chain");

endmodule

// File: tb/sv/earliest_free_worker_scheduler_core_test.sv
// Self-checking testbench for the earliest-free worker scheduler core.
module earliest_free_worker_scheduler_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int START_BITS        = efws_pkg::START_BITS;
  localparam int DURATION_BITS     = efws_pkg::DURATION_BITS;
  localparam int ID_FIELD_BITS     = efws_pkg::ID_FIELD_BITS;
  localparam int CFG_ADDR_BITS     = efws_pkg::CFG_ADDR_BITS;
  localparam int CFG_DATA_BITS     = efws_pkg::CFG_DATA_BITS;
  localparam int WORKER_COUNT_BITS = efws_pkg::WORKER_COUNT_BITS;
  localparam int PAD_BITS          = CFG_DATA_BITS - WORKER_COUNT_BITS;

  localparam int NUM_WORKERS = 16;
  localparam logic [START_BITS-1:0] TIME_MAX = '1;
  localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;
  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 23;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [ID_FIELD_BITS-1:0] id;
    logic [START_BITS-1:0]    start;
  } grant_t;

  typedef logic [WORKER_COUNT_BITS-1:0] count_t;

  // DUT connections, all inputs known from time zero
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         job_valid = 1'b0;
  logic                         job_stall;
  logic [DURATION_BITS-1:0]     job_duration = '0;
  logic                         grant_valid;
  logic                         grant_stall = 1'b0;
  logic [ID_FIELD_BITS-1:0]     worker_id;
  logic [START_BITS-1:0]        start_time;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]     paddr = '0;
  logic [CFG_DATA_BITS-1:0]     pwdata = '0;
  logic [CFG_DATA_BITS-1:0]     prdata;
  logic                         pready;

  // Scheduler mirror: free time per worker, indexed by id
  logic [START_BITS-1:0]        free_at [NUM_WORKERS];
  logic [WORKER_COUNT_BITS-1:0] worker_count_q;
  grant_t                       pending_grants [$];
  grant_t                       got_grant;

  int     mismatches = 0;
  longint cycle_count = 0;
  bit     idle_on = 1'b1;
  logic   hold_req = 1'b0;
  int     hold_left = 0;

  earliest_free_worker_scheduler_core dut (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_stall    (job_stall),
    .job_duration (job_duration),
    .grant_valid  (grant_valid),
    .grant_stall  (grant_stall),
    .worker_id    (worker_id),
    .start_time   (start_time),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reload: every worker free at time zero
  task automatic clear_free_times(input logic [WORKER_COUNT_BITS-1:0] count);
    worker_count_q = count;
    for (int k = 0; k < NUM_WORKERS; k++) free_at[k] = '0;
  endtask

  // Pick the earliest free worker (lower id wins ties), queue its grant, book the job
  task automatic book_job(input logic [DURATION_BITS-1:0] dur);
    int            active;
    int            best;
    logic [START_BITS:0] sum;
    grant_t        g;
    active = int'(worker_count_q);
    if (active < 1) active = 1;
    if (active > NUM_WORKERS) active = NUM_WORKERS;
    best = 0;
    for (int k = 1; k < active; k++)
      if (free_at[k] < free_at[best]) best = k;
    g.id = best[ID_FIELD_BITS-1:0];
    g.start = free_at[best];
    pending_grants.insert(pending_grants.size(), g);
    // free time saturates at the top of its range
    sum = {1'b0, free_at[best]} + (START_BITS+1)'(dur);
    if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
    free_at[best] = sum[START_BITS-1:0];
  endtask

  // Offer one job and wait for its transfer; called at a rising edge
  task automatic send_job(input logic [DURATION_BITS-1:0] dur);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      job_valid <= 1'b0;
      job_duration <= $urandom();
      @(posedge clk);
    end
    job_valid <= 1'b1;
    job_duration <= dur;
    do @(posedge clk); while (job_stall);
    book_job(dur);
  endtask

  // Stop offering jobs and let every grant drain
  task automatic drain_grants();
    job_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the worker count, only with the block idle
  task automatic write_worker_count(input logic [WORKER_COUNT_BITS-1:0] count);
    drain_grants();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= efws_pkg::REG_WORKER_COUNT;
    pwdata <= {PAD_BITS'($urandom()), count};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    clear_free_times(count);
    @(posedge clk);
  endtask

  // Random job length: ties from short and zero jobs, some maximum jobs, full range otherwise
  function automatic logic [DURATION_BITS-1:0] rand_duration();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(0, 7);
    if (r < 40) return '0;
    if (r < 45) return DUR_MAX;
    return $urandom();
  endfunction

  // Grant checker
  always @(posedge clk) begin
    if (!rst && grant_valid && !grant_stall) begin
      if (pending_grants.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("grant with none expected: id %0d start %0d", worker_id, start_time);
        mismatches++;
      end else begin
        got_grant = pending_grants.pop_front();
        if (worker_id !== got_grant.id || start_time !== got_grant.start) begin
          if (mismatches < MAX_REPORTS)
            $display("grant mismatch: expected id %0d start %0d, got id %0d start %0d",
                     got_grant.id, got_grant.start, worker_id, start_time);
          mismatches++;
        end
      end
    end
  end

  // Receiver stalls: long hold-off on request, random stalls otherwise while idling is on
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      grant_stall <= 1'b1;
      hold_left--;
    end else begin
      grant_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Reset count of 16, field extremes, ties at time zero
  task automatic test_reset_defaults();
    send_job('0);
    send_job(DUR_MAX);
    send_job(32'h8000_0000);
    send_job(32'h0000_0001);
    send_job(32'h7FFF_FFFF);
    for (int k = 0; k < 11; k++) send_job(k[DURATION_BITS-1:0]);
    send_job(32'h5555_AAAA);
    drain_grants();
  endtask

  // Worker count of zero, one, maximum and above maximum
  task automatic test_count_extremes();
    write_worker_count(5'd0);
    repeat (3) send_job(32'd5);
    write_worker_count(5'd1);
    repeat (3) send_job(32'd2);
    write_worker_count(5'd17);
    repeat (17) send_job(32'd1);
    write_worker_count(5'd31);
    repeat (3) send_job(32'd0);
    write_worker_count(5'd16);
    repeat (3) send_job(32'd9);
    drain_grants();
  endtask

  // Few workers, back-to-back maximum jobs push free times far past 32 bits
  task automatic test_long_jobs();
    idle_on = 1'b0;
    write_worker_count(5'd1);
    repeat (40) send_job(DUR_MAX);
    send_job('0);
    send_job(32'd1);
    write_worker_count(5'd2);
    repeat (40) send_job(DUR_MAX);
    drain_grants();
    idle_on = 1'b1;
  endtask

  // Receiver holds off while jobs keep coming, so the job side backs up
  task automatic test_backpressure();
    write_worker_count(5'd4);
    hold_req <= 1'b1;
    repeat (60) send_job(rand_duration());
    drain_grants();
  endtask

  // Random jobs over a series of worker counts, one phase with no idling
  task automatic test_random_jobs();
    logic [WORKER_COUNT_BITS-1:0] count;
    for (int phase = 0; phase < 11; phase++) begin
      unique case (phase)
        0: count = 5'd16;
        1: count = 5'd1;
        2: count = 5'd31;
        3: count = 5'd0;
        default: count = ($urandom_range(99) < 80) ? count_t'($urandom_range(1, 16))
                                                   : count_t'($urandom_range(0, 31));
      endcase
      idle_on = (phase != 5);
      write_worker_count(count);
      repeat (150) send_job(rand_duration());
    end
    idle_on = 1'b1;
    drain_grants();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    clear_free_times(efws_pkg::WORKER_COUNT_RESET);
    @(posedge clk);

    test_reset_defaults();
    test_count_extremes();
    test_backpressure();
    test_random_jobs();
    test_long_jobs();

    drain_grants();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
